/* design/slxfr_pkg.sv */
// shared types and constants of the frame receiver
`default_nettype none
package slxfr_pkg;

  localparam int BUF_DEPTH   = 256;
  localparam int MAX_PAYLOAD = 64;
  localparam int SOF_COUNT   = 2;
  localparam int HDR_LEN     = SOF_COUNT + 1;
  localparam int AW          = $clog2(BUF_DEPTH);
  localparam int CW          = ((AW > 8) ? AW : 8) + 1;
  localparam int LEN_W       = 7;

  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_PKT  = 2'd1;
  localparam logic [1:0] CMD_BYTE = 2'd2;

  localparam logic [2:0] REG_SOF0    = 3'd0;
  localparam logic [2:0] REG_SOF1    = 3'd1;
  localparam logic [2:0] REG_MINLEN  = 3'd2;
  localparam logic [2:0] REG_MAXLEN  = 3'd3;
  localparam logic [2:0] REG_TIMEOUT = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE, ST_POP, ST_SCAN, ST_CHK0, ST_CHK1, ST_HDR, ST_LEN,
    ST_SUM, ST_EMIT, ST_OUT, ST_OUT_PAY
  } state_t;

  typedef enum logic [2:0] {
    OFF_ZERO, OFF_ONE, OFF_LEN, OFF_DATA, OFF_NEXT
  } off_sel_t;

  typedef enum logic [2:0] {
    OUT_HOLD, OUT_NONE, OUT_DROPPED, OUT_RAW, OUT_EMPTY, OUT_PAYLOAD
  } out_kind_t;

  typedef struct packed {
    logic      accept;
    logic      push;
    logic      rd_en;
    off_sel_t  off;
    logic      drop1;
    logic      consume;
    logic      set_wait;
    logic      load_len;
    logic      xor_step;
    logic      cnt_clr;
    logic      cnt_inc;
    out_kind_t out_load;
  } ctl_t;

  typedef struct packed {
    logic full;
    logic fill_zero;
    logic fill_lt_sof;
    logic fill_lt_hdr;
    logic sof0_ok;
    logic sof1_ok;
    logic len_bad;
    logic need_more;
    logic waiting;
    logic timeout_hit;
    logic cnt_at_len;
    logic sum_ok;
    logic len_zero;
    logic last_byte;
  } sts_t;

endpackage
`default_nettype wire

/* design/slxfr_ram.sv */
// generic single write port ram with registered read
`default_nettype none
module slxfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* design/slxfr_ctrl.sv */
// controller state machine of the frame receiver
`default_nettype none
module slxfr_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  input  wire logic [1:0]        s_tuser,
  input  wire logic              m_tready,
  input  wire slxfr_pkg::sts_t   sts,
  output slxfr_pkg::ctl_t        ctl,
  output logic                   s_tready,
  output logic                   m_tvalid
);

  slxfr_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= slxfr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    ctl          = '0;
    ctl.off      = slxfr_pkg::OFF_ZERO;
    ctl.out_load = slxfr_pkg::OUT_HOLD;
    s_tready     = 1'b0;
    m_tvalid     = 1'b0;
    unique case (state)
      slxfr_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          ctl.accept = 1'b1;
          priority if (s_tuser == slxfr_pkg::CMD_PUSH) begin
            ctl.push     = 1'b1;
            ctl.out_load = sts.full ? slxfr_pkg::OUT_DROPPED : slxfr_pkg::OUT_NONE;
            state_next   = slxfr_pkg::ST_OUT;
          end else if (s_tuser == slxfr_pkg::CMD_PKT) begin
            state_next = slxfr_pkg::ST_SCAN;
          end else if (s_tuser == slxfr_pkg::CMD_BYTE && !sts.fill_zero) begin
            ctl.rd_en  = 1'b1;
            state_next = slxfr_pkg::ST_POP;
          end else begin
            ctl.out_load = slxfr_pkg::OUT_NONE;
            state_next   = slxfr_pkg::ST_OUT;
          end
        end
      end
      slxfr_pkg::ST_POP: begin
        ctl.out_load = slxfr_pkg::OUT_RAW;
        ctl.drop1    = 1'b1;
        state_next   = slxfr_pkg::ST_OUT;
      end
      slxfr_pkg::ST_SCAN: begin
        if (sts.fill_lt_sof) begin
          ctl.out_load = slxfr_pkg::OUT_NONE;
          state_next   = slxfr_pkg::ST_OUT;
        end else begin
          ctl.rd_en  = 1'b1;
          state_next = slxfr_pkg::ST_CHK0;
        end
      end
      slxfr_pkg::ST_CHK0: begin
        if (!sts.sof0_ok) begin
          ctl.drop1  = 1'b1;
          state_next = slxfr_pkg::ST_SCAN;
        end else if (slxfr_pkg::SOF_COUNT >= 2) begin
          ctl.rd_en  = 1'b1;
          ctl.off    = slxfr_pkg::OFF_ONE;
          state_next = slxfr_pkg::ST_CHK1;
        end else begin
          state_next = slxfr_pkg::ST_HDR;
        end
      end
      slxfr_pkg::ST_CHK1: begin
        if (!sts.sof1_ok) begin
          ctl.drop1  = 1'b1;
          state_next = slxfr_pkg::ST_SCAN;
        end else begin
          state_next = slxfr_pkg::ST_HDR;
        end
      end
      slxfr_pkg::ST_HDR: begin
        if (sts.fill_lt_hdr) begin
          ctl.out_load = slxfr_pkg::OUT_NONE;
          state_next   = slxfr_pkg::ST_OUT;
        end else begin
          ctl.rd_en  = 1'b1;
          ctl.off    = slxfr_pkg::OFF_LEN;
          state_next = slxfr_pkg::ST_LEN;
        end
      end
      slxfr_pkg::ST_LEN: begin
        priority if (sts.len_bad) begin
          ctl.drop1  = 1'b1;
          state_next = slxfr_pkg::ST_SCAN;
        end else if (sts.need_more) begin
          if (!sts.waiting) begin
            ctl.set_wait = 1'b1;
            ctl.out_load = slxfr_pkg::OUT_NONE;
            state_next   = slxfr_pkg::ST_OUT;
          end else if (sts.timeout_hit) begin
            ctl.drop1  = 1'b1;
            state_next = slxfr_pkg::ST_SCAN;
          end else begin
            ctl.out_load = slxfr_pkg::OUT_NONE;
            state_next   = slxfr_pkg::ST_OUT;
          end
        end else begin
          ctl.load_len = 1'b1;
          ctl.cnt_clr  = 1'b1;
          ctl.rd_en    = 1'b1;
          ctl.off      = slxfr_pkg::OFF_DATA;
          state_next   = slxfr_pkg::ST_SUM;
        end
      end
      slxfr_pkg::ST_SUM: begin
        priority if (!sts.cnt_at_len) begin
          ctl.xor_step = 1'b1;
          ctl.cnt_inc  = 1'b1;
          ctl.rd_en    = 1'b1;
          ctl.off      = slxfr_pkg::OFF_NEXT;
        end else if (!sts.sum_ok) begin
          ctl.drop1  = 1'b1;
          state_next = slxfr_pkg::ST_SCAN;
        end else if (sts.len_zero) begin
          ctl.out_load = slxfr_pkg::OUT_EMPTY;
          ctl.consume  = 1'b1;
          state_next   = slxfr_pkg::ST_OUT;
        end else begin
          ctl.cnt_clr = 1'b1;
          ctl.rd_en   = 1'b1;
          ctl.off     = slxfr_pkg::OFF_DATA;
          state_next  = slxfr_pkg::ST_EMIT;
        end
      end
      slxfr_pkg::ST_EMIT: begin
        ctl.out_load = slxfr_pkg::OUT_PAYLOAD;
        state_next   = slxfr_pkg::ST_OUT_PAY;
      end
      slxfr_pkg::ST_OUT_PAY: begin
        m_tvalid = 1'b1;
        if (m_tready) begin
          if (sts.last_byte) begin
            ctl.consume = 1'b1;
            state_next  = slxfr_pkg::ST_IDLE;
          end else begin
            ctl.cnt_inc = 1'b1;
            ctl.rd_en   = 1'b1;
            ctl.off     = slxfr_pkg::OFF_NEXT;
            state_next  = slxfr_pkg::ST_EMIT;
          end
        end
      end
      slxfr_pkg::ST_OUT: begin
        m_tvalid = 1'b1;
        if (m_tready) begin
          state_next = slxfr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = slxfr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

/* design/slxfr_dp.sv */
// datapath of the frame receiver: ring, indexes, checksum, result register
`default_nettype none
module slxfr_dp (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire slxfr_pkg::ctl_t   ctl,
  output slxfr_pkg::sts_t        sts,
  input  wire logic [39:0]       s_tdata,
  input  wire logic              cfg_we,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [15:0]       cfg_data,
  output logic [15:0]            m_tdata,
  output logic [1:0]             m_tuser,
  output logic                   m_tlast
);

  localparam int AW = slxfr_pkg::AW;
  localparam int CW = slxfr_pkg::CW;
  localparam int LW = slxfr_pkg::LEN_W;

  logic [AW-1:0] write_idx, read_idx;
  logic          waiting;
  logic [31:0]   start_ms;
  logic [31:0]   now_ms;
  logic [7:0]    sof0, sof1;
  logic [LW-1:0] min_len, max_len;
  logic [15:0]   timeout;
  logic [LW-1:0] dlen, cnt;
  logic [7:0]    xacc;
  logic          out_ok, out_drop, out_last;
  logic [7:0]    out_data;
  logic [LW-1:0] out_len;

  logic [7:0]    rdata;
  logic [AW-1:0] fill, raddr, off;
  logic [CW-1:0] fill_w, need_rd, need_q, off_w;
  logic [LW-1:0] max_eff;
  logic [31:0]   elapsed;
  logic          full;

  assign fill    = write_idx - read_idx;
  assign fill_w  = CW'(fill);
  assign full    = (write_idx + AW'(1)) == read_idx;
  assign need_rd = CW'(slxfr_pkg::HDR_LEN + 1) + CW'(rdata);
  assign need_q  = CW'(slxfr_pkg::HDR_LEN + 1) + CW'(dlen);
  assign max_eff = (max_len < LW'(slxfr_pkg::MAX_PAYLOAD)) ? max_len
                                                           : LW'(slxfr_pkg::MAX_PAYLOAD);
  assign elapsed = now_ms - start_ms;

  always_comb begin
    off_w = '0;
    unique case (ctl.off)
      slxfr_pkg::OFF_ZERO: off_w = '0;
      slxfr_pkg::OFF_ONE:  off_w = CW'(1);
      slxfr_pkg::OFF_LEN:  off_w = CW'(slxfr_pkg::SOF_COUNT);
      slxfr_pkg::OFF_DATA: off_w = CW'(slxfr_pkg::HDR_LEN);
      slxfr_pkg::OFF_NEXT: off_w = CW'(slxfr_pkg::HDR_LEN + 1) + CW'(cnt);
      default:             off_w = '0;
    endcase
  end

  assign off   = off_w[AW-1:0];
  assign raddr = read_idx + off;

  slxfr_ram #(
    .WIDTH(8),
    .DEPTH(slxfr_pkg::BUF_DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (ctl.push && !full),
    .waddr(write_idx),
    .wdata(s_tdata[7:0]),
    .re   (ctl.rd_en),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    sts             = '0;
    sts.full        = full;
    sts.fill_zero   = (fill == '0);
    sts.fill_lt_sof = fill_w < CW'(slxfr_pkg::SOF_COUNT);
    sts.fill_lt_hdr = fill_w < CW'(slxfr_pkg::HDR_LEN);
    sts.sof0_ok     = (rdata == sof0);
    sts.sof1_ok     = (rdata == sof1);
    sts.len_bad     = (rdata < {1'b0, min_len}) || (rdata > {1'b0, max_eff});
    sts.need_more   = fill_w < need_rd;
    sts.waiting     = waiting;
    sts.timeout_hit = (timeout != '0) && (elapsed >= {16'd0, timeout});
    sts.cnt_at_len  = (cnt == dlen);
    sts.sum_ok      = (xacc == rdata);
    sts.len_zero    = (dlen == '0);
    sts.last_byte   = out_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_idx <= '0;
      read_idx  <= '0;
      waiting   <= 1'b0;
      start_ms  <= '0;
      sof0      <= 8'd170;
      sof1      <= 8'd85;
      min_len   <= '0;
      max_len   <= LW'(64);
      timeout   <= 16'd100;
    end else begin
      if (ctl.push && !full) begin
        write_idx <= write_idx + AW'(1);
      end
      if (ctl.drop1) begin
        read_idx <= read_idx + AW'(1);
        waiting  <= 1'b0;
      end else if (ctl.consume) begin
        read_idx <= read_idx + need_q[AW-1:0];
        waiting  <= 1'b0;
      end else if (ctl.set_wait) begin
        waiting  <= 1'b1;
        start_ms <= now_ms;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          slxfr_pkg::REG_SOF0:    sof0    <= cfg_data[7:0];
          slxfr_pkg::REG_SOF1:    sof1    <= cfg_data[7:0];
          slxfr_pkg::REG_MINLEN:  min_len <= cfg_data[LW-1:0];
          slxfr_pkg::REG_MAXLEN:  max_len <= cfg_data[LW-1:0];
          slxfr_pkg::REG_TIMEOUT: timeout <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      now_ms <= s_tdata[39:8];
    end
    if (ctl.load_len) begin
      dlen <= rdata[LW-1:0];
      xacc <= rdata;
    end else if (ctl.xor_step) begin
      xacc <= xacc ^ rdata;
    end
    if (ctl.cnt_clr) begin
      cnt <= '0;
    end else if (ctl.cnt_inc) begin
      cnt <= cnt + LW'(1);
    end
    unique case (ctl.out_load)
      slxfr_pkg::OUT_HOLD: ;
      slxfr_pkg::OUT_NONE, slxfr_pkg::OUT_DROPPED: begin
        out_ok   <= 1'b0;
        out_data <= '0;
        out_len  <= '0;
        out_last <= 1'b1;
        out_drop <= (ctl.out_load == slxfr_pkg::OUT_DROPPED);
      end
      slxfr_pkg::OUT_RAW: begin
        out_ok   <= 1'b1;
        out_data <= rdata;
        out_len  <= '0;
        out_last <= 1'b1;
        out_drop <= 1'b0;
      end
      slxfr_pkg::OUT_EMPTY: begin
        out_ok   <= 1'b1;
        out_data <= '0;
        out_len  <= '0;
        out_last <= 1'b1;
        out_drop <= 1'b0;
      end
      slxfr_pkg::OUT_PAYLOAD: begin
        out_ok   <= 1'b1;
        out_data <= rdata;
        out_len  <= dlen;
        out_last <= (cnt + LW'(1)) == dlen;
        out_drop <= 1'b0;
      end
      default: ;
    endcase
  end

  assign m_tdata = {1'b0, out_len, out_data};
  assign m_tuser = {out_drop, out_ok};
  assign m_tlast = out_last;

endmodule
`default_nettype wire

/* design/sof_len_xor_frame_receiver.sv */
// top level of the frame receiver
// one item at a time; a push or unused command goes straight to the output, a raw byte read pops a
// byte first, each then waits for the output; a packet read walks the ring through the single ram read
// port: a scan step per byte dropped on a bad first start byte, then header, checksum and delivery
// ring is 256 bytes, holds 255; its contents are undefined after reset
// synchronous reset clears indexes, timeout state and restores register defaults
`default_nettype none
module sof_len_xor_frame_receiver (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,  // rx_byte, now_ms
  input  wire logic [1:0]  s_tuser,  // cmd
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,  // data_byte, frame_length, zero pad
  output logic [1:0]       m_tuser,  // ok, byte_dropped
  output logic             m_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  slxfr_pkg::ctl_t ctl;
  slxfr_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  slxfr_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tuser (s_tuser),
    .m_tready(m_tready),
    .sts     (sts),
    .ctl     (ctl),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid)
  );

  slxfr_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
`default_nettype wire
